[rtl/abbi_pkg.sv]
`default_nettype none

package abbi_pkg;

  // config register width and reset value
  localparam int unsigned CFG_W = 6;
  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 6'd4;

  // per-block flip rule
  localparam logic [1:0] MODE_ALL   = 2'd0;
  localparam logic [1:0] MODE_ODD   = 2'd1;
  localparam logic [1:0] MODE_THIRD = 2'd2;

  localparam logic [1:0] THIRD_LAST = 2'd2;

  typedef struct packed {
    logic coded_bit;
    logic final_bit;
  } res_word_t;

endpackage

`default_nettype wire

[rtl/abbi_if.sv]
`default_nettype none

interface abbi_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic stream_end;

  modport source (output valid, output data_bit, output stream_end, input ready);
  modport sink (input valid, input data_bit, input stream_end, output ready);
endinterface

interface abbi_out_if;
  logic valid;
  logic ready;
  logic coded_bit;
  logic final_bit;

  modport source (output valid, output coded_bit, output final_bit, input ready);
  modport sink (input valid, input coded_bit, input final_bit, output ready);
endinterface

interface abbi_cfg_if
  import abbi_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] block_size;

  modport source (output valid, output block_size, input ready);
  modport sink (input valid, input block_size, output ready);
endinterface

`default_nettype wire

[rtl/abbi_enc.sv]
`default_nettype none

module abbi_enc
  import abbi_pkg::*;
#(
  parameter int MAX_BLOCK = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CFG_W-1:0] block_size,
  input  wire logic             in_valid,
  input  wire logic             in_data_bit,
  input  wire logic             in_stream_end,
  output logic                  in_ready,
  output logic                  res_valid,
  output res_word_t             res_word,
  input  wire logic             res_ready
);

  localparam int PW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int OW = $clog2(MAX_BLOCK + 1);
  localparam logic [CFG_W-1:0] MAX_SZ = CFG_W'(MAX_BLOCK);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [OW-1:0] ones_r, ones_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [1:0]    third_r, third_nxt;
  logic          pad_r, pad_nxt;

  logic             step;
  logic             b;
  logic             ending;
  logic             flip;
  logic             closed;
  logic [CFG_W-1:0] eff_size;
  logic [CFG_W-1:0] held;
  logic [CFG_W-1:0] ones_ext;
  logic [CFG_W-1:0] zeros;
  logic [OW-1:0]    ones_inc;
  logic [1:0]       close_mode;

  // padding zeros go out while the input is held off
  assign in_ready  = !pad_r && res_ready;
  assign res_valid = pad_r || in_valid;
  assign step      = res_valid && res_ready;
  assign b         = pad_r ? 1'b0 : in_data_bit;
  assign ending    = pad_r || in_stream_end;

  always_comb begin
    if (block_size == '0) begin
      eff_size = CFG_W'(1);
    end else if (block_size > MAX_SZ) begin
      eff_size = MAX_SZ;
    end else begin
      eff_size = block_size;
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_ODD:   flip = pos_r[0];
      MODE_THIRD: flip = (third_r == THIRD_LAST);
      default:    flip = 1'b1;
    endcase
  end

  assign ones_inc = ones_r + OW'(b);
  assign held     = CFG_W'(pos_r) + CFG_W'(1);
  assign ones_ext = CFG_W'(ones_inc);
  assign zeros    = held - ones_ext;
  assign closed   = (held >= eff_size);

  always_comb begin
    if (ones_ext == zeros) begin
      close_mode = MODE_ALL;
    end else if (zeros > ones_ext) begin
      close_mode = MODE_ODD;
    end else begin
      close_mode = MODE_THIRD;
    end
  end

  assign res_word.coded_bit = b ^ flip;
  assign res_word.final_bit = ending && closed;

  always_comb begin
    pos_nxt   = pos_r;
    ones_nxt  = ones_r;
    mode_nxt  = mode_r;
    third_nxt = third_r;
    pad_nxt   = pad_r;
    if (step) begin
      if (closed) begin
        pos_nxt   = '0;
        ones_nxt  = '0;
        third_nxt = '0;
        // end of stream: back to the first-block rule
        mode_nxt  = ending ? MODE_ALL : close_mode;
        pad_nxt   = 1'b0;
      end else begin
        pos_nxt   = PW'(held);
        ones_nxt  = ones_inc;
        third_nxt = (third_r == THIRD_LAST) ? 2'd0 : third_r + 2'd1;
        pad_nxt   = ending;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ones_r  <= '0;
      mode_r  <= MODE_ALL;
      third_r <= '0;
      pad_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      ones_r  <= ones_nxt;
      mode_r  <= mode_nxt;
      third_r <= third_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/abbi_skid.sv]
`default_nettype none

module abbi_skid
  import abbi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  input  res_word_t       up_word,
  output logic            up_ready,
  output logic            dn_valid,
  output res_word_t       dn_word,
  input  wire logic       dn_ready
);

  logic      out_v_r, out_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  res_word_t out_word_r, out_word_nxt;
  res_word_t skid_word_r, skid_word_nxt;
  logic      push;
  logic      pop;

  // ready comes from a flop only
  assign up_ready = !skid_v_r;
  assign push     = up_valid && up_ready;
  assign pop      = dn_ready || !out_v_r;
  assign dn_valid = out_v_r;
  assign dn_word  = out_word_r;

  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    out_word_nxt  = out_word_r;
    skid_word_nxt = skid_word_r;
    if (pop) begin
      if (skid_v_r) begin
        out_word_nxt = skid_word_r;
        out_v_nxt    = 1'b1;
        skid_v_nxt   = 1'b0;
      end else if (push) begin
        out_word_nxt = up_word;
        out_v_nxt    = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_word_nxt = up_word;
      skid_v_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

endmodule

`default_nettype wire

[rtl/adaptive_block_bit_inverter.sv]
`default_nettype none

// Adaptive block bit inverter: a bit-serial encoder that takes one plain bit
// per cycle while in_ready is high and presents its encoded bit on the out
// channel. Each input word yields one output word, except the word that
// carries stream_end: it yields the rest of its block as zero padding, one
// output word per cycle while the skid accepts, with the input channel
// stalled meanwhile. The encode step is a position counter, a ones counter, a
// third counter, a padding flag and a stored rule, all updated together; a
// two-entry registered output skid absorbs one word when the consumer stalls.
// block_size (reset 4) should only be written while the encoder is idle; 0
// acts as 1 and values above MAX_BLOCK act as MAX_BLOCK. After the final bit
// the encoder returns to its first-block rule for the next stream.
module adaptive_block_bit_inverter
  import abbi_pkg::*;
#(
  parameter int MAX_BLOCK = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  abbi_in_if.sink    in_ch,
  abbi_out_if.source out_ch,
  abbi_cfg_if.sink   cfg_ch
);

  logic [CFG_W-1:0] block_size_r;

  logic      res_valid;
  logic      res_ready;
  res_word_t res_word;
  res_word_t dn_word;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
    end else if (cfg_ch.valid) begin
      block_size_r <= cfg_ch.block_size;
    end
  end

  abbi_enc #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .block_size    (block_size_r),
    .in_valid      (in_ch.valid),
    .in_data_bit   (in_ch.data_bit),
    .in_stream_end (in_ch.stream_end),
    .in_ready      (in_ch.ready),
    .res_valid     (res_valid),
    .res_word      (res_word),
    .res_ready     (res_ready)
  );

  abbi_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (res_valid),
    .up_word  (res_word),
    .up_ready (res_ready),
    .dn_valid (out_ch.valid),
    .dn_word  (dn_word),
    .dn_ready (out_ch.ready)
  );

  assign out_ch.coded_bit = dn_word.coded_bit;
  assign out_ch.final_bit = dn_word.final_bit;

endmodule

`default_nettype wire
